### sv/pf_pkg.sv
// Shared constants and types for the trial-division prime factorizer.
package pf_pkg;

    localparam int WIDTH       = 32;
    localparam int DATA_W      = 32;
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int BIT_W       = $clog2(WIDTH);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DIV    = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_SEND   = 5'b01000,
        ST_FIN    = 5'b10000
    } t_state;

endpackage

### sv/prime_factorizer_top.sv
// Trial-division prime factorizer with a bit-serial restoring divider.
// Each trial divisor goes through the divider (ST_DIV) and then a decision state
// (ST_DECIDE); each result is then sent from ST_SEND, a leftover final prime passing
// through ST_FIN first; a prime near 2^32 takes about 65536 trial divisors. Values are
// taken one at a time; the next once the current one's last result is in the output reg.
// Reset (synchronous, active low) clears the state machine, counters and valid flags.
module prime_factorizer_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [pf_pkg::DATA_W-1:0] i_s_axis_tdata,   // [31:0] n
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [pf_pkg::DATA_W-1:0] o_m_axis_tdata,   // [31:0] factor
    output logic                      o_m_axis_tlast,
    output logic                      o_m_axis_tuser    // [0] no_factor
);
    import pf_pkg::*;

    t_state             r_state, n_state;
    t_state             r_snext, n_snext;
    logic [WIDTH-1:0]   r_rem, n_rem;
    logic [WIDTH-1:0]   r_d, n_d;
    logic [WIDTH-1:0]   r_sh, n_sh;
    logic [WIDTH-1:0]   r_part, n_part;
    logic [BIT_W-1:0]   r_bit, n_bit;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_chk, n_chk;
    logic [WIDTH-1:0]   r_pend, n_pend;
    logic               r_pend_v, n_pend_v;
    logic [WIDTH-1:0]   r_fin, n_fin;
    logic [WIDTH-1:0]   r_sf, n_sf;
    logic               r_sl, n_sl;
    logic               r_sn, n_sn;
    logic               r_ov, n_ov;
    logic [DATA_W-1:0]  r_of, n_of;
    logic               r_ol, n_ol;
    logic               r_on, n_on;

    logic [WIDTH:0]     shl;
    logic               ge;
    logic [WIDTH-1:0]   diff;
    logic [WIDTH-1:0]   n_in;
    logic               out_free;

    assign n_in     = WIDTH'(i_s_axis_tdata);
    assign shl      = {r_part, r_sh[WIDTH-1]};
    assign ge       = shl >= {1'b0, r_d};
    assign diff     = shl[WIDTH-1:0] - r_d;
    assign out_free = !r_ov || i_m_axis_tready;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_of;
    assign o_m_axis_tlast  = r_ol;
    assign o_m_axis_tuser  = r_on;

    always_comb begin
        n_state  = r_state;
        n_snext  = r_snext;
        n_rem    = r_rem;
        n_d      = r_d;
        n_sh     = r_sh;
        n_part   = r_part;
        n_bit    = r_bit;
        n_cnt    = r_cnt;
        n_chk    = r_chk;
        n_pend   = r_pend;
        n_pend_v = r_pend_v;
        n_fin    = r_fin;
        n_sf     = r_sf;
        n_sl     = r_sl;
        n_sn     = r_sn;
        n_ov     = r_ov;
        n_of     = r_of;
        n_ol     = r_ol;
        n_on     = r_on;

        if (r_ov && i_m_axis_tready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_rem    = n_in;
                    n_d      = WIDTH'(2);
                    n_cnt    = '0;
                    n_pend_v = 1'b0;
                    n_chk    = 1'b1;
                    n_sh     = n_in;
                    n_part   = '0;
                    n_bit    = '0;
                    if (n_in == WIDTH'(1)) begin
                        n_sf    = '0;
                        n_sl    = 1'b1;
                        n_sn    = 1'b1;
                        n_snext = ST_IDLE;
                        n_state = ST_SEND;
                    end else begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                n_part = ge ? diff : shl[WIDTH-1:0];
                n_sh   = {r_sh[WIDTH-2:0], ge};
                n_bit  = r_bit + BIT_W'(1);
                if (r_bit == BIT_W'(WIDTH - 1)) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                // r_sh holds rem / d, r_part holds rem % d
                n_part = '0;
                n_bit  = '0;
                if (r_chk && (r_d > r_sh)) begin
                    n_sn = 1'b0;
                    if (r_rem != WIDTH'(1)) begin
                        n_fin = r_rem;
                        if (r_pend_v) begin
                            n_sf    = r_pend;
                            n_sl    = 1'b0;
                            n_snext = ST_FIN;
                            n_state = ST_SEND;
                        end else begin
                            n_state = ST_FIN;
                        end
                    end else begin
                        n_sf    = r_pend;
                        n_sl    = 1'b1;
                        n_snext = ST_IDLE;
                        n_state = ST_SEND;
                    end
                end else if (r_part == '0) begin
                    n_cnt    = r_cnt + CNT_W'(1);
                    n_rem    = r_sh;
                    n_chk    = 1'b0;
                    n_sn     = 1'b0;
                    n_sl     = 1'b0;
                    n_sf     = r_pend;
                    n_pend   = r_d;
                    n_pend_v = 1'b1;
                    if (r_cnt + CNT_W'(1) == CNT_W'(MAX_RESULTS)) begin
                        n_fin = r_d;
                        if (r_pend_v) begin
                            n_snext = ST_FIN;
                            n_state = ST_SEND;
                        end else begin
                            n_state = ST_FIN;
                        end
                    end else if (r_pend_v) begin
                        n_snext = ST_DIV;
                        n_state = ST_SEND;
                    end else begin
                        n_state = ST_DIV;
                    end
                end else begin
                    n_d     = r_d + WIDTH'(1);
                    n_chk   = 1'b1;
                    n_sh    = r_rem;
                    n_state = ST_DIV;
                end
            end
            ST_FIN: begin
                n_sf    = r_fin;
                n_sl    = 1'b1;
                n_sn    = 1'b0;
                n_snext = ST_IDLE;
                n_state = ST_SEND;
            end
            ST_SEND: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_of    = DATA_W'(r_sf);
                    n_ol    = r_sl;
                    n_on    = r_sn;
                    n_state = r_snext;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_snext  <= ST_IDLE;
            r_ov     <= 1'b0;
            r_pend_v <= 1'b0;
            r_chk    <= 1'b0;
            r_cnt    <= '0;
            r_bit    <= '0;
        end else begin
            r_state  <= n_state;
            r_snext  <= n_snext;
            r_ov     <= n_ov;
            r_pend_v <= n_pend_v;
            r_chk    <= n_chk;
            r_cnt    <= n_cnt;
            r_bit    <= n_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_d    <= n_d;
        r_sh   <= n_sh;
        r_part <= n_part;
        r_pend <= n_pend;
        r_fin  <= n_fin;
        r_sf   <= n_sf;
        r_sl   <= n_sl;
        r_sn   <= n_sn;
        r_of   <= n_of;
        r_ol   <= n_ol;
        r_on   <= n_on;
    end

endmodule
